// File: design/rrfp_pkg.sv
// Shared types and constants for the radar report frame parser.
// No dependencies; imported by rrfp_parser and radar_report_frame_parser.
package rrfp_pkg;

  // Payload store address width; covers every payload length up to 63 bytes.
  localparam int PL_AW = 6;

  localparam logic [7:0] HDR_SEQ  [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
  localparam logic [7:0] TAIL_SEQ [4] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

  // Write into the payload store
  typedef struct packed {
    logic             en;
    logic [PL_AW-1:0] addr;
    logic [7:0]       data;
  } pl_wr_t;

endpackage

// File: design/rrfp_parser.sv
// Byte-level frame parser: header hunt, length check, payload write, tail check.
// Depends on rrfp_pkg; drives payload store writes and the frame-done pulse.
module rrfp_parser import rrfp_pkg::*; #(
  parameter int PAYLOAD_LEN = 35
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  data_byte,
  output pl_wr_t      wr,
  output logic        frame_done,
  output logic [7:0]  status_r,
  output logic [15:0] dist_r
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_L   = 3'd1,
    PH_LEN_H   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TAIL    = 3'd4
  } phase_t;

  localparam int CNT_W = PL_AW;

  phase_t           phase_r;
  logic [1:0]       hdr_cnt_r;
  logic [1:0]       tail_cnt_r;
  logic [7:0]       len_lo_r;
  logic [CNT_W-1:0] pay_cnt_r;
  logic [CNT_W-1:0] pay_cnt_nxt;

  assign pay_cnt_nxt = pay_cnt_r + CNT_W'(1);

  assign wr.en   = take && (phase_r == PH_PAYLOAD);
  assign wr.addr = pay_cnt_r[PL_AW-1:0];
  assign wr.data = data_byte;

  assign frame_done = take && (phase_r == PH_TAIL) &&
                      (data_byte == TAIL_SEQ[tail_cnt_r]) && (tail_cnt_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      hdr_cnt_r  <= 2'd0;
      tail_cnt_r <= 2'd0;
      len_lo_r   <= 8'd0;
      pay_cnt_r  <= '0;
    end else if (take) begin
      unique case (phase_r)
        PH_LEN_L: begin
          len_lo_r <= data_byte;
          phase_r  <= PH_LEN_H;
        end
        PH_LEN_H: begin
          if ({data_byte, len_lo_r} != 16'(PAYLOAD_LEN)) begin
            phase_r <= PH_HUNT;
          end else begin
            pay_cnt_r <= '0;
            phase_r   <= PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          pay_cnt_r <= pay_cnt_nxt;
          if (pay_cnt_nxt == CNT_W'(PAYLOAD_LEN)) begin
            tail_cnt_r <= 2'd0;
            phase_r    <= PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (data_byte == TAIL_SEQ[tail_cnt_r]) begin
            if (tail_cnt_r == 2'd3) begin
              tail_cnt_r <= 2'd0;
              phase_r    <= PH_HUNT;
            end else begin
              tail_cnt_r <= tail_cnt_r + 2'd1;
            end
          end else begin
            phase_r <= PH_HUNT;
          end
        end
        default: begin
          // mismatching byte is dropped, not retried as a header start
          phase_r <= PH_HUNT;
          if (data_byte == HDR_SEQ[hdr_cnt_r]) begin
            if (hdr_cnt_r == 2'd3) begin
              hdr_cnt_r <= 2'd0;
              phase_r   <= PH_LEN_L;
            end else begin
              hdr_cnt_r <= hdr_cnt_r + 2'd1;
            end
          end else begin
            hdr_cnt_r <= 2'd0;
          end
        end
      endcase
    end
  end

  // Keep status and distance as they stream past
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (pay_cnt_r == CNT_W'(0)) status_r     <= data_byte;
      if (pay_cnt_r == CNT_W'(1)) dist_r[7:0]  <= data_byte;
      if (pay_cnt_r == CNT_W'(2)) dist_r[15:8] <= data_byte;
    end
  end

endmodule

// File: design/radar_report_frame_parser.sv
// Top level of the radar report frame parser: payload store and gate emitter.
// Depends on rrfp_pkg and rrfp_parser.
//
// Accepts one serial byte per cycle while parsing. Bytes are matched against
// the F4 F3 F2 F1 header, a little-endian length that must equal PAYLOAD_LEN,
// PAYLOAD_LEN payload bytes written into a single-port-read payload store, and
// the F8 F7 F6 F5 tail. A good tail starts a burst of NUM_GATES results, one
// per range gate; in_stall is high for the whole burst. Each gate takes two
// registered reads of the payload store (energy low and high byte), then
// loads the output register once out_stall allows; a gate whose high byte
// lies past the payload store gets zero energy. No clearing pass is needed
// after reset.
module radar_report_frame_parser import rrfp_pkg::*; #(
  parameter int PAYLOAD_LEN = 35,
  parameter int NUM_GATES   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_target_present,
  output logic [15:0] out_target_dist,
  output logic [3:0]  out_gate_index,
  output logic [15:0] out_gate_energy,
  output logic        out_last_gate
);

  typedef enum logic [1:0] {
    E_IDLE,
    E_LO,
    E_HI,
    E_OUT
  } emit_t;

  emit_t            state_r;
  logic [3:0]       gate_r;
  logic [7:0]       lo_byte_r;
  logic [7:0]       rd_data_r;
  logic             out_valid_r;
  logic [7:0]       mem [PAYLOAD_LEN];

  logic             take;
  pl_wr_t           wr;
  logic             frame_done;
  logic [7:0]       status_r;
  logic [15:0]      dist_r;
  logic [PL_AW-1:0] lo_addr;
  logic [PL_AW-1:0] hi_addr;
  logic             gate_ok;
  logic             rd_en;
  logic [PL_AW-1:0] rd_addr;
  logic             out_free;
  logic             last;

  assign in_stall = !rst_n || (state_r != E_IDLE);
  assign take     = in_valid && !in_stall;

  rrfp_parser #(
    .PAYLOAD_LEN(PAYLOAD_LEN)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_data_byte),
    .wr         (wr),
    .frame_done (frame_done),
    .status_r   (status_r),
    .dist_r     (dist_r)
  );

  assign lo_addr = PL_AW'(3) + {1'b0, gate_r, 1'b0};
  assign hi_addr = lo_addr + PL_AW'(1);
  assign gate_ok = (hi_addr < PL_AW'(PAYLOAD_LEN));
  assign rd_en   = gate_ok && ((state_r == E_LO) || (state_r == E_HI));
  assign rd_addr = (state_r == E_HI) ? hi_addr : lo_addr;
  assign out_free = !out_valid_r || !out_stall;
  assign last     = (gate_r == 4'(NUM_GATES - 1));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      gate_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      // a reload in E_OUT keeps valid high
      if (out_valid_r && !out_stall && (state_r != E_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        E_IDLE: begin
          if (frame_done) begin
            gate_r  <= 4'd0;
            state_r <= E_LO;
          end
        end
        E_LO: begin
          state_r <= E_HI;
        end
        E_HI: begin
          lo_byte_r <= rd_data_r;
          state_r   <= E_OUT;
        end
        E_OUT: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_target_present <= status_r;
            out_target_dist    <= dist_r;
            out_gate_index     <= gate_r;
            out_gate_energy    <= gate_ok ? {rd_data_r, lo_byte_r} : 16'd0;
            out_last_gate      <= last;
            if (last) begin
              state_r <= E_IDLE;
            end else begin
              gate_r  <= gate_r + 4'd1;
              state_r <= E_LO;
            end
          end
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule
